/* hw/rtl/fcd_pkg.sv */
`timescale 1ns / 1ps

package fcd_pkg;

   // Fixed field widths
   localparam int PIX_W    = 16;
   localparam int MODE_W   = 2;
   localparam int COLS_W   = 9;
   localparam int ROWS_W   = 8;
   localparam int THRESH_W = 17;
   localparam int COUNT_W  = 17;
   localparam int MARK_W   = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Default frame store geometry
   localparam int DEF_MAX_COLS = 320;
   localparam int DEF_MAX_ROWS = 240;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Marker for an empty bounding box
   localparam logic [MARK_W-1:0] NONE_MARK = 16'hFFFF;

   // Pixel formation modes (codes 0 and 1 both blend)
   localparam logic [MODE_W-1:0] MODE_BLEND  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NATIVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_COLS   = 2'd1;
   localparam logic [1:0] REG_ROWS   = 2'd2;
   localparam logic [1:0] REG_THRESH = 2'd3;

   // Register reset values
   localparam logic [MODE_W-1:0]   RST_MODE   = MODE_BLEND;
   localparam logic [COLS_W-1:0]   RST_COLS   = 9'd320;
   localparam logic [ROWS_W-1:0]   RST_ROWS   = 8'd240;
   localparam logic [THRESH_W-1:0] RST_THRESH = 17'd9600;

   // Result kinds
   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [COLS_W-1:0]   cols;
      logic [ROWS_W-1:0]   rows;
      logic [THRESH_W-1:0] thresh;
   } cfg_type;

endpackage

/* hw/rtl/fcd_queue.sv */
`timescale 1ns / 1ps

module fcd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = fcd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

/* hw/rtl/fcd_front.sv */
`timescale 1ns / 1ps

module fcd_front #(
   parameter int MAX_COLS = fcd_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = fcd_pkg::DEF_MAX_ROWS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fcd_pkg::cfg_type                      cfg,
   input  logic                                  req_valid,
   input  logic [fcd_pkg::PIX_W-1:0]             req_top_left,
   input  logic [fcd_pkg::PIX_W-1:0]             req_top_right,
   input  logic [fcd_pkg::PIX_W-1:0]             req_bottom_left,
   input  logic [fcd_pkg::PIX_W-1:0]             req_bottom_right,
   input  logic                                  queue_full,
   input  logic                                  clear_busy,
   output logic                                  req_stall,
   output logic                                  push_valid,
   output logic [fcd_pkg::PIX_W-1:0]             push_pix,
   output logic [$clog2(MAX_ROWS)-1:0]           push_row,
   output logic [$clog2(MAX_COLS)-1:0]           push_col,
   output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]  push_addr,
   output logic                                  push_end
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
   localparam int CW1    = $clog2(MAX_COLS + 1);
   localparam int RW1    = $clog2(MAX_ROWS + 1);

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [CW1-1:0]   cols_eff, col_next1;
   logic [RW1-1:0]   rows_eff, row_next1;
   logic             accept, row_end, frame_end;

   function automatic logic [fcd_pkg::PIX_W-1:0] make_pixel(
      input logic [fcd_pkg::MODE_W-1:0] mode,
      input logic [fcd_pkg::PIX_W-1:0]  tl,
      input logic [fcd_pkg::PIX_W-1:0]  tr,
      input logic [fcd_pkg::PIX_W-1:0]  bl,
      input logic [fcd_pkg::PIX_W-1:0]  br
   );
      logic [7:0] r, g, b;
      logic [fcd_pkg::PIX_W-1:0] pix;
      // widen each channel to six bits, then sum or scale to eight
      r = {2'b00, tl[15:11], 1'b0};
      g = {2'b00, tl[10:5]};
      b = {2'b00, tl[4:0], 1'b0};
      if (mode == fcd_pkg::MODE_SINGLE) begin
         r = r << 2;
         g = g << 2;
         b = b << 2;
      end else begin
         r = r + {2'b00, tr[15:11], 1'b0} + {2'b00, bl[15:11], 1'b0}
               + {2'b00, br[15:11], 1'b0};
         g = g + {2'b00, tr[10:5]} + {2'b00, bl[10:5]} + {2'b00, br[10:5]};
         b = b + {2'b00, tr[4:0], 1'b0} + {2'b00, bl[4:0], 1'b0}
               + {2'b00, br[4:0], 1'b0};
      end
      pix = {r[7:3], g[7:2], b[7:3]};
      if (mode == fcd_pkg::MODE_NATIVE) begin
         pix = tl;
      end
      return pix;
   endfunction

   // clamp the frame size into 1..MAX
   always_comb begin
      if (cfg.cols == '0) begin
         cols_eff = CW1'(1);
      end else if (32'(cfg.cols) > 32'(MAX_COLS)) begin
         cols_eff = CW1'(MAX_COLS);
      end else begin
         cols_eff = CW1'(cfg.cols);
      end
      if (cfg.rows == '0) begin
         rows_eff = RW1'(1);
      end else if (32'(cfg.rows) > 32'(MAX_ROWS)) begin
         rows_eff = RW1'(MAX_ROWS);
      end else begin
         rows_eff = RW1'(cfg.rows);
      end
   end

   assign req_stall = queue_full || clear_busy;
   assign accept    = req_valid && !req_stall;

   assign col_next1 = CW1'(col_ff) + CW1'(1);
   assign row_next1 = RW1'(row_ff) + RW1'(1);
   assign row_end   = (col_next1 >= cols_eff);
   assign frame_end = row_end && (row_next1 >= rows_eff);

   always_comb begin
      col_in = row_end ? '0 : COL_W'(col_next1);
      row_in = row_ff;
      if (row_end) begin
         row_in = frame_end ? '0 : ROW_W'(row_next1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign push_valid = accept;
   assign push_pix   = make_pixel(cfg.mode, req_top_left, req_top_right,
                                  req_bottom_left, req_bottom_right);
   assign push_row   = row_ff;
   assign push_col   = col_ff;
   assign push_addr  = ADDR_W'(row_ff) * ADDR_W'(MAX_COLS) + ADDR_W'(col_ff);
   assign push_end   = frame_end;

endmodule

/* hw/rtl/fcd_back.sv */
`timescale 1ns / 1ps

module fcd_back #(
   parameter int MAX_COLS = fcd_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = fcd_pkg::DEF_MAX_ROWS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fcd_pkg::cfg_type                      cfg,
   input  logic                                  pop_valid,
   input  logic [fcd_pkg::PIX_W-1:0]             pop_pix,
   input  logic [$clog2(MAX_ROWS)-1:0]           pop_row,
   input  logic [$clog2(MAX_COLS)-1:0]           pop_col,
   input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]  pop_addr,
   input  logic                                  pop_end,
   output logic                                  pop,
   output logic                                  clear_busy,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic                                  rsp_kind,
   output logic [fcd_pkg::PIX_W-1:0]             rsp_pixel_value,
   output logic [$clog2(MAX_ROWS)-1:0]           rsp_row,
   output logic [$clog2(MAX_COLS)-1:0]           rsp_col,
   output logic                                  rsp_changed,
   output logic [fcd_pkg::COUNT_W-1:0]           rsp_change_count,
   output logic [fcd_pkg::MARK_W-1:0]            rsp_first_row,
   output logic [$clog2(MAX_ROWS)-1:0]           rsp_last_row,
   output logic [fcd_pkg::MARK_W-1:0]            rsp_first_col,
   output logic [$clog2(MAX_COLS)-1:0]           rsp_last_col,
   output logic                                  rsp_large_update,
   output logic                                  rsp_last
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PIX_W  = fcd_pkg::PIX_W;
   localparam int CNT_W  = fcd_pkg::COUNT_W;
   localparam int MARK_W = fcd_pkg::MARK_W;

   // frame store
   logic [PIX_W-1:0]  mem [DEPTH];
   logic [PIX_W-1:0]  mem_rd_ff;
   logic              fwd_ff;
   logic [PIX_W-1:0]  fwd_pix_ff;
   logic              we;
   logic [ADDR_W-1:0] wa;
   logic [PIX_W-1:0]  wd;

   // clearing sweep
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // execute slot
   logic              r_valid_ff, r_phase_ff;
   logic [PIX_W-1:0]  r_pix_ff;
   logic [ROW_W-1:0]  r_row_ff;
   logic [COL_W-1:0]  r_col_ff;
   logic [ADDR_W-1:0] r_addr_ff;
   logic              r_end_ff;

   // frame statistics
   logic [CNT_W-1:0]  count_ff;
   logic [MARK_W-1:0] min_row_ff, min_col_ff;
   logic [ROW_W-1:0]  max_row_ff;
   logic [COL_W-1:0]  max_col_ff;

   logic [PIX_W-1:0]  prev_pix;
   logic              changed, out_free, commit, commit_pix, commit_sum, r_done, load;

   assign clear_busy = clr_busy_ff;

   assign prev_pix   = fwd_ff ? fwd_pix_ff : mem_rd_ff;
   assign changed    = (prev_pix != r_pix_ff);
   assign out_free   = !rsp_valid || !rsp_stall;
   assign commit     = r_valid_ff && out_free;
   assign commit_pix = commit && !r_phase_ff;
   assign commit_sum = commit && r_phase_ff;
   assign r_done     = commit && (r_phase_ff || !r_end_ff);
   assign load       = pop_valid && !clr_busy_ff && (!r_valid_ff || r_done);
   assign pop        = load;

   assign we = clr_busy_ff || (commit_pix && changed);
   assign wa = clr_busy_ff ? clr_addr_ff : r_addr_ff;
   assign wd = clr_busy_ff ? '0 : r_pix_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (load) begin
         mem_rd_ff <= mem[pop_addr];
      end
   end

   // bypass a write that lands on the edge of the read
   always_ff @(posedge clock) begin
      if (load) begin
         fwd_ff     <= commit_pix && (r_addr_ff == pop_addr);
         fwd_pix_ff <= r_pix_ff;
         r_pix_ff   <= pop_pix;
         r_row_ff   <= pop_row;
         r_col_ff   <= pop_col;
         r_addr_ff  <= pop_addr;
         r_end_ff   <= pop_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         r_phase_ff <= 1'b0;
      end else if (load) begin
         r_valid_ff <= 1'b1;
         r_phase_ff <= 1'b0;
      end else if (r_done) begin
         r_valid_ff <= 1'b0;
         r_phase_ff <= 1'b0;
      end else if (commit_pix) begin
         r_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         min_row_ff <= fcd_pkg::NONE_MARK;
         max_row_ff <= '0;
         min_col_ff <= fcd_pkg::NONE_MARK;
         max_col_ff <= '0;
      end else if (commit_sum) begin
         count_ff   <= '0;
         min_row_ff <= fcd_pkg::NONE_MARK;
         max_row_ff <= '0;
         min_col_ff <= fcd_pkg::NONE_MARK;
         max_col_ff <= '0;
      end else if (commit_pix && changed) begin
         if (count_ff != '1) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (MARK_W'(r_row_ff) < min_row_ff) begin
            min_row_ff <= MARK_W'(r_row_ff);
         end
         if (r_row_ff > max_row_ff) begin
            max_row_ff <= r_row_ff;
         end
         if (MARK_W'(r_col_ff) < min_col_ff) begin
            min_col_ff <= MARK_W'(r_col_ff);
         end
         if (r_col_ff > max_col_ff) begin
            max_col_ff <= r_col_ff;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (commit) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_pix) begin
         rsp_kind         <= fcd_pkg::KIND_PIXEL;
         rsp_pixel_value  <= r_pix_ff;
         rsp_row          <= r_row_ff;
         rsp_col          <= r_col_ff;
         rsp_changed      <= changed;
         rsp_change_count <= '0;
         rsp_first_row    <= '0;
         rsp_last_row     <= '0;
         rsp_first_col    <= '0;
         rsp_last_col     <= '0;
         rsp_large_update <= 1'b0;
         rsp_last         <= !r_end_ff;
      end else if (commit_sum) begin
         rsp_kind         <= fcd_pkg::KIND_SUMMARY;
         rsp_pixel_value  <= '0;
         rsp_row          <= '0;
         rsp_col          <= '0;
         rsp_changed      <= 1'b0;
         rsp_change_count <= count_ff;
         rsp_first_row    <= min_row_ff;
         rsp_last_row     <= max_row_ff;
         rsp_first_col    <= min_col_ff;
         rsp_last_col     <= max_col_ff;
         rsp_large_update <= (count_ff >= cfg.thresh);
         rsp_last         <= 1'b1;
      end
   end

   a_no_work_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !r_valid_ff && !rsp_valid)
      else $error("item in flight during store clearing");

   a_summary_follows_end: assert property (@(posedge clock) disable iff (reset)
      commit_pix && r_end_ff |=> r_valid_ff && r_phase_ff)
      else $error("frame end pixel not followed by summary");

   a_stats_cleared: assert property (@(posedge clock) disable iff (reset)
      commit_sum |=> count_ff == '0 && min_row_ff == fcd_pkg::NONE_MARK
                     && min_col_ff == fcd_pkg::NONE_MARK)
      else $error("frame statistics not cleared after summary");

   a_summary_is_last: assert property (@(posedge clock) disable iff (reset)
      commit_sum |=> rsp_valid && rsp_kind == fcd_pkg::KIND_SUMMARY && rsp_last)
      else $error("summary result malformed");

endmodule

/* hw/rtl/frame_change_detector.sv */
`timescale 1ns / 1ps

// Frame change detector.
// Input channel (req_): one output pixel per item, in raster order, carried as
// the four RGB565 samples of its 2x2 source block. Accepted on a rising edge
// with req_valid high and req_stall low.
// Result channel (rsp_): one pixel result per item (rsp_kind 0) carrying the
// packed pixel, its row/column and a changed flag against the frame store;
// the frame's last pixel adds a summary result (rsp_kind 1) with change count,
// bounding box and large-update flag. rsp_last marks an item's final result.
// Throughput: one item per cycle within a frame while the result channel is not
// stalled; the frame's last item also holds the result stage for its summary,
// a bubble that the internal queue hides only for short bursts.
// Path: an accepted item goes through the queue and the execute slot to the
// output register, which raises rsp_valid.
// Reset: synchronous; the frame store is swept to zero, one entry a cycle, over
// all MAX_ROWS*MAX_COLS entries (76800 by default) with req_stall held high.
// Registers can be written over the APB-style port during the sweep.
// A stalled result holds; the queue then fills and req_stall rises.

module frame_change_detector #(
   parameter int MAX_COLS = fcd_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = fcd_pkg::DEF_MAX_ROWS
) (
   input  logic                                  clock,
   input  logic                                  reset,

   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [fcd_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [fcd_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [fcd_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready,

   // input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fcd_pkg::PIX_W-1:0]             req_top_left,
   input  logic [fcd_pkg::PIX_W-1:0]             req_top_right,
   input  logic [fcd_pkg::PIX_W-1:0]             req_bottom_left,
   input  logic [fcd_pkg::PIX_W-1:0]             req_bottom_right,

   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_kind,
   output logic [fcd_pkg::PIX_W-1:0]             rsp_pixel_value,
   output logic [$clog2(MAX_ROWS)-1:0]           rsp_row,
   output logic [$clog2(MAX_COLS)-1:0]           rsp_col,
   output logic                                  rsp_changed,
   output logic [fcd_pkg::COUNT_W-1:0]           rsp_change_count,
   output logic [fcd_pkg::MARK_W-1:0]            rsp_first_row,
   output logic [$clog2(MAX_ROWS)-1:0]           rsp_last_row,
   output logic [fcd_pkg::MARK_W-1:0]            rsp_first_col,
   output logic [$clog2(MAX_COLS)-1:0]           rsp_last_col,
   output logic                                  rsp_large_update,
   output logic                                  rsp_last
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
   localparam int PIX_W  = fcd_pkg::PIX_W;
   localparam int ENTRY_W = PIX_W + ROW_W + COL_W + ADDR_W + 1;

   // configuration registers
   logic [fcd_pkg::MODE_W-1:0]   mode_ff;
   logic [fcd_pkg::COLS_W-1:0]   cols_ff;
   logic [fcd_pkg::ROWS_W-1:0]   rows_ff;
   logic [fcd_pkg::THRESH_W-1:0] thresh_ff;
   logic [1:0]                   csr_index;
   logic                         csr_write;
   fcd_pkg::cfg_type             cfg;

   // front to queue
   logic              push_valid;
   logic [PIX_W-1:0]  push_pix;
   logic [ROW_W-1:0]  push_row;
   logic [COL_W-1:0]  push_col;
   logic [ADDR_W-1:0] push_addr;
   logic              push_end;

   // queue to back
   logic [ENTRY_W-1:0] pop_data;
   logic               queue_full, queue_empty, pop, clear_busy;

   // register write: word addressed, index from paddr[3:2]
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= fcd_pkg::RST_MODE;
         cols_ff   <= fcd_pkg::RST_COLS;
         rows_ff   <= fcd_pkg::RST_ROWS;
         thresh_ff <= fcd_pkg::RST_THRESH;
      end else if (csr_write) begin
         case (csr_index)
            fcd_pkg::REG_MODE:   mode_ff   <= csr_pwdata[fcd_pkg::MODE_W-1:0];
            fcd_pkg::REG_COLS:   cols_ff   <= csr_pwdata[fcd_pkg::COLS_W-1:0];
            fcd_pkg::REG_ROWS:   rows_ff   <= csr_pwdata[fcd_pkg::ROWS_W-1:0];
            fcd_pkg::REG_THRESH: thresh_ff <= csr_pwdata[fcd_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // read back, zero-extended
   always_comb begin
      case (csr_index)
         fcd_pkg::REG_MODE:   csr_prdata = fcd_pkg::CSR_DATA_W'(mode_ff);
         fcd_pkg::REG_COLS:   csr_prdata = fcd_pkg::CSR_DATA_W'(cols_ff);
         fcd_pkg::REG_ROWS:   csr_prdata = fcd_pkg::CSR_DATA_W'(rows_ff);
         fcd_pkg::REG_THRESH: csr_prdata = fcd_pkg::CSR_DATA_W'(thresh_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // field order follows cfg_type: mode, cols, rows, thresh
   assign cfg = {mode_ff, cols_ff, rows_ff, thresh_ff};

   // front: form the pixel, track raster position, compute store address
   fcd_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_top_left     (req_top_left),
      .req_top_right    (req_top_right),
      .req_bottom_left  (req_bottom_left),
      .req_bottom_right (req_bottom_right),
      .queue_full       (queue_full),
      .clear_busy       (clear_busy),
      .req_stall        (req_stall),
      .push_valid       (push_valid),
      .push_pix         (push_pix),
      .push_row         (push_row),
      .push_col         (push_col),
      .push_addr        (push_addr),
      .push_end         (push_end)
   );

   // decouple front and back so each can stall on its own
   fcd_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (fcd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_pix, push_row, push_col, push_addr, push_end}),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // back: store read-modify-write, statistics, results
   fcd_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .pop_valid        (!queue_empty),
      .pop_pix          (pop_data[ENTRY_W-1 -: PIX_W]),
      .pop_row          (pop_data[ENTRY_W-PIX_W-1 -: ROW_W]),
      .pop_col          (pop_data[ADDR_W+COL_W -: COL_W]),
      .pop_addr         (pop_data[ADDR_W -: ADDR_W]),
      .pop_end          (pop_data[0]),
      .pop              (pop),
      .clear_busy       (clear_busy),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_row          (rsp_row),
      .rsp_col          (rsp_col),
      .rsp_changed      (rsp_changed),
      .rsp_change_count (rsp_change_count),
      .rsp_first_row    (rsp_first_row),
      .rsp_last_row     (rsp_last_row),
      .rsp_first_col    (rsp_first_col),
      .rsp_last_col     (rsp_last_col),
      .rsp_large_update (rsp_large_update),
      .rsp_last         (rsp_last)
   );

endmodule
